// ===== hw/rtl/imu6bq_pkg.sv =====
package imu6bq_pkg;

    // Coefficient registers are Q2.16 style, 18 bits signed.
    localparam int COEF_W    = 18;
    localparam int WARM_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Ten fields per word; the first six are filter lanes (accel 0..2, gyro 3..5).
    localparam int NUM_FLD   = 10;
    localparam int NUM_LANES = 6;
    localparam int LANE_W    = 3;
    localparam int GYRO_BASE = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic signed [COEF_W-1:0] t_coef;

    localparam t_cfg_idx REG_ACC_B0  = 3'd0;
    localparam t_cfg_idx REG_ACC_A1  = 3'd1;
    localparam t_cfg_idx REG_ACC_A2  = 3'd2;
    localparam t_cfg_idx REG_GYR_B0  = 3'd3;
    localparam t_cfg_idx REG_GYR_A1  = 3'd4;
    localparam t_cfg_idx REG_GYR_A2  = 3'd5;
    localparam t_cfg_idx REG_WARMUP  = 3'd6;

    localparam t_coef B0_RST = 18'sd19195;
    localparam t_coef A1_RST = 18'sd0;
    localparam t_coef A2_RST = 18'sd11244;

endpackage

// ===== hw/rtl/imu_six_axis_biquad_lowpass_core.sv =====
// Words are filtered channel by channel through the single shared multiplier
// (three products per filtered channel) and the history memory. The input
// skid word lets the next word be accepted while the current one is filtered.
// Reset (synchronous, active low) restores the coefficient defaults, clears the
// warmup counter, empties all stages and marks every history entry as zero.
module imu_six_axis_biquad_lowpass_core #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 16,
    parameter int AXES           = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_accel_x_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_accel_y_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_accel_z_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_gyro_x_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_gyro_y_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_gyro_z_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_temp_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_mag_x_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_mag_y_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_mag_z_in,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      o_accel_x_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_accel_y_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_accel_z_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_gyro_x_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_gyro_y_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_gyro_z_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_temp_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_mag_x_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_mag_y_out,
    output logic signed [SAMPLE_WIDTH-1:0]      o_mag_z_out,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [imu6bq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [imu6bq_pkg::COEF_W-1:0]       i_cfg_data
);

    // Sizes. The filter input term is x + 2*x1 + x2, which needs two extra bits.
    // Every product and the accumulator share one width that covers
    // b0*sum - a1*y1 - a2*y2 without overflow.
    localparam int SW   = SAMPLE_WIDTH;
    localparam int CW   = imu6bq_pkg::COEF_W;
    localparam int NCH  = 2 * AXES;
    localparam int CH_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int XW   = SW + 2;
    localparam int PW   = CW + XW;
    localparam int NF   = imu6bq_pkg::NUM_FLD;
    localparam int LW   = imu6bq_pkg::LANE_W;

    // Rounding adds one half LSB of the integer result, then an arithmetic
    // shift floors it; the bounds below saturate to the sample range.
    localparam logic signed [PW:0] HALF   =
        {{(PW + 1 - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
    localparam logic signed [PW:0] SAT_HI = {{(PW + 2 - SW){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic signed [PW:0] SAT_LO = {{(PW + 2 - SW){1'b1}}, {(SW - 1){1'b0}}};

    // One history entry per filtered channel: two past inputs, two past outputs.
    typedef struct packed {
        logic signed [SW-1:0] x1;
        logic signed [SW-1:0] x2;
        logic signed [SW-1:0] y1;
        logic signed [SW-1:0] y2;
    } t_hist;

    // Per channel the sequencer walks SUM, MB0, MA1, MA2, ACC, WRITE. The next
    // channel's history read is issued during WRITE, so READ appears only once
    // per word.
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_MB0,
        S_MA1,
        S_MA2,
        S_ACC,
        S_WRITE,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [CH_W-1:0]        r_ch;

    // Configuration registers.
    imu6bq_pkg::t_coef      r_ac_b0, r_ac_a1, r_ac_a2;
    imu6bq_pkg::t_coef      r_gy_b0, r_gy_a1, r_gy_a2;
    logic [imu6bq_pkg::WARM_W-1:0] r_warmup;
    logic [imu6bq_pkg::WARM_W-1:0] r_warm_cnt;
    logic                   r_warm;

    // Input skid word, working word and output word.
    logic                   r_in_full;
    logic signed [SW-1:0]   r_in  [NF];
    logic signed [SW-1:0]   r_res [NF];
    logic                   r_out_valid;
    logic signed [SW-1:0]   r_out [NF];

    // History memory with registered read and per-entry valid bits.
    t_hist                  r_mem [NCH];
    t_hist                  r_rd;
    logic                   r_rd_vld;
    logic [NCH-1:0]         r_hv;

    // Datapath registers.
    logic signed [XW-1:0]   r_sum;
    logic signed [PW-1:0]   r_prod;
    logic signed [PW-1:0]   r_acc;

    logic signed [SW-1:0]   w_in [NF];
    logic                   w_in_fire;
    logic                   w_out_free;
    logic                   w_last;
    logic                   w_is_gyro;
    logic [LW-1:0]          w_lane;
    logic                   w_rd_en;
    logic [CH_W-1:0]        w_rd_addr;
    logic                   w_wr_en;
    t_hist                  w_wr_data;
    logic signed [SW-1:0]   w_x, w_x1, w_x2, w_y1, w_y2;
    logic signed [XW-1:0]   w_sum;
    imu6bq_pkg::t_coef      w_b0, w_a1, w_a2;
    imu6bq_pkg::t_coef      w_mul_a;
    logic signed [XW-1:0]   w_mul_b;
    logic signed [PW-1:0]   w_mul;
    logic signed [PW:0]     w_biased;
    logic signed [PW:0]     w_rnd;
    logic signed [SW-1:0]   w_sat;
    logic signed [SW-1:0]   w_y;

    assign w_in[0] = i_accel_x_in;
    assign w_in[1] = i_accel_y_in;
    assign w_in[2] = i_accel_z_in;
    assign w_in[3] = i_gyro_x_in;
    assign w_in[4] = i_gyro_y_in;
    assign w_in[5] = i_gyro_z_in;
    assign w_in[6] = i_temp_in;
    assign w_in[7] = i_mag_x_in;
    assign w_in[8] = i_mag_y_in;
    assign w_in[9] = i_mag_z_in;

    assign o_accel_x_out = r_out[0];
    assign o_accel_y_out = r_out[1];
    assign o_accel_z_out = r_out[2];
    assign o_gyro_x_out  = r_out[3];
    assign o_gyro_y_out  = r_out[4];
    assign o_gyro_z_out  = r_out[5];
    assign o_temp_out    = r_out[6];
    assign o_mag_x_out   = r_out[7];
    assign o_mag_y_out   = r_out[8];
    assign o_mag_z_out   = r_out[9];

    // The input stage frees as soon as the sequencer copies the word in, so a
    // new word can wait there while the current one is being filtered.
    assign o_in_ready  = !r_in_full;
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign w_in_fire   = i_in_valid && !r_in_full;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Channel numbering: accel axes first, then gyro axes. Lanes of unused
    // axes keep the copied input, which gives the pass-through behavior.
    assign w_last    = (r_ch == CH_W'(NCH - 1));
    assign w_is_gyro = (r_ch >= CH_W'(AXES));
    assign w_lane    = w_is_gyro ? LW'(LW'(r_ch) - LW'(AXES) + LW'(imu6bq_pkg::GYRO_BASE))
                                 : LW'(r_ch);

    // A read of the next channel overlaps the write-back of the current one;
    // the two addresses always differ, so no forwarding is required.
    assign w_rd_en   = (r_state == S_READ) || ((r_state == S_WRITE) && !w_last);
    assign w_rd_addr = (r_state == S_WRITE) ? CH_W'(r_ch + 1'b1) : r_ch;
    assign w_wr_en   = (r_state == S_WRITE);

    // Entries never written since reset read as zero history.
    assign w_x  = r_res[w_lane];
    assign w_x1 = r_rd_vld ? r_rd.x1 : '0;
    assign w_x2 = r_rd_vld ? r_rd.x2 : '0;
    assign w_y1 = r_rd_vld ? r_rd.y1 : '0;
    assign w_y2 = r_rd_vld ? r_rd.y2 : '0;

    // Because b1 = 2*b0 and b2 = b0, the feed-forward part collapses into one
    // product of b0 with x + 2*x1 + x2.
    assign w_sum = {{2{w_x[SW-1]}}, w_x} + {w_x1[SW-1], w_x1, 1'b0} + {{2{w_x2[SW-1]}}, w_x2};

    assign w_b0 = w_is_gyro ? r_gy_b0 : r_ac_b0;
    assign w_a1 = w_is_gyro ? r_gy_a1 : r_ac_a1;
    assign w_a2 = w_is_gyro ? r_gy_a2 : r_ac_a2;

    always_comb begin
        case (r_state)
            S_MA1: begin
                w_mul_a = w_a1;
                w_mul_b = {{2{w_y1[SW-1]}}, w_y1};
            end
            S_MA2: begin
                w_mul_a = w_a2;
                w_mul_b = {{2{w_y2[SW-1]}}, w_y2};
            end
            default: begin
                w_mul_a = w_b0;
                w_mul_b = r_sum;
            end
        endcase
    end

    // The single shared multiplier.
    assign w_mul = PW'(w_mul_a) * PW'(w_mul_b);

    // Round half up, then saturate to the sample range.
    assign w_biased = {r_acc[PW-1], r_acc} + HALF;
    assign w_rnd    = w_biased >>> COEF_FRAC_BITS;
    always_comb begin
        if (w_rnd > SAT_HI) begin
            w_sat = SAT_HI[SW-1:0];
        end else if (w_rnd < SAT_LO) begin
            w_sat = SAT_LO[SW-1:0];
        end else begin
            w_sat = w_rnd[SW-1:0];
        end
    end

    // During warmup the filter echoes its input, but the history still moves.
    assign w_y = r_warm ? w_x : w_sat;

    assign w_wr_data.x1 = w_x;
    assign w_wr_data.x2 = w_x1;
    assign w_wr_data.y1 = w_y;
    assign w_wr_data.y2 = w_y1;

    // History memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_ch] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_in_full   <= 1'b0;
            r_out_valid <= 1'b0;
            r_hv        <= '0;
            r_rd_vld    <= 1'b0;
            r_warm      <= 1'b0;
            r_warm_cnt  <= '0;
            r_warmup    <= '0;
            r_ac_b0     <= imu6bq_pkg::B0_RST;
            r_ac_a1     <= imu6bq_pkg::A1_RST;
            r_ac_a2     <= imu6bq_pkg::A2_RST;
            r_gy_b0     <= imu6bq_pkg::B0_RST;
            r_gy_a1     <= imu6bq_pkg::A1_RST;
            r_gy_a2     <= imu6bq_pkg::A2_RST;
        end else begin
            // Register writes; an index past the last register is dropped.
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    imu6bq_pkg::REG_ACC_B0: r_ac_b0  <= i_cfg_data;
                    imu6bq_pkg::REG_ACC_A1: r_ac_a1  <= i_cfg_data;
                    imu6bq_pkg::REG_ACC_A2: r_ac_a2  <= i_cfg_data;
                    imu6bq_pkg::REG_GYR_B0: r_gy_b0  <= i_cfg_data;
                    imu6bq_pkg::REG_GYR_A1: r_gy_a1  <= i_cfg_data;
                    imu6bq_pkg::REG_GYR_A2: r_gy_a2  <= i_cfg_data;
                    imu6bq_pkg::REG_WARMUP: r_warmup <= i_cfg_data[imu6bq_pkg::WARM_W-1:0];
                    default: ;
                endcase
            end

            if (w_in_fire) begin
                r_in_full <= 1'b1;
                for (int i = 0; i < NF; i++) begin
                    r_in[i] <= w_in[i];
                end
            end

            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_rd_en) begin
                r_rd_vld <= r_hv[w_rd_addr];
            end

            case (r_state)
                S_IDLE: begin
                    if (r_in_full) begin
                        r_in_full <= 1'b0;
                        for (int i = 0; i < NF; i++) begin
                            r_res[i] <= r_in[i];
                        end
                        // The warmup decision uses the register as it stands now,
                        // so raising it later reopens warmup.
                        if (r_warm_cnt < r_warmup) begin
                            r_warm     <= 1'b1;
                            r_warm_cnt <= r_warm_cnt + 1'b1;
                        end else begin
                            r_warm <= 1'b0;
                        end
                        r_ch    <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= w_sum;
                    r_state <= S_MB0;
                end
                S_MB0: begin
                    r_prod  <= w_mul;
                    r_state <= S_MA1;
                end
                S_MA1: begin
                    r_acc   <= r_prod;
                    r_prod  <= w_mul;
                    r_state <= S_MA2;
                end
                S_MA2: begin
                    r_acc   <= r_acc - r_prod;
                    r_prod  <= w_mul;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= r_acc - r_prod;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_hv[r_ch]    <= 1'b1;
                    r_res[w_lane] <= w_y;
                    if (w_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ch    <= CH_W'(r_ch + 1'b1);
                        r_state <= S_SUM;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        for (int i = 0; i < NF; i++) begin
                            r_out[i] <= r_res[i];
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The overlapped read and write-back must never touch the same entry.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd_en && w_wr_en) |-> (w_rd_addr != r_ch))
        else $error("history read and write hit the same entry");

    // After the last channel is written back the word goes to the output stage.
    a_last_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WRITE) && w_last) |=> (r_state == S_DONE))
        else $error("sequencer did not finish after the last channel");

    // A finished word is presented as soon as the output register is free.
    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && w_out_free) |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("finished word was not presented");

    // A word taken from the input stage starts at channel zero with a fresh read.
    a_start_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && r_in_full) |=> ((r_state == S_READ) && (r_ch == '0)))
        else $error("new word did not start at the first channel");

endmodule
